// ----- design/sacp_pkg.sv -----
// Package for the set-associative cache unit with next-line prefetch.
// Holds sizes, the line and row layout, the transaction payload types and the set helpers.
// No dependencies.
package sacp_pkg;

  localparam int MAX_SETS   = 256;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_BITS  = 48;
  localparam int OFFSET_CAP = 12;
  localparam int SET_W      = $clog2(MAX_SETS);
  localparam int WAY_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W     = $clog2(MAX_WAYS + 1);

  localparam logic [2:0] CFG_OFFSET_BITS = 3'd0;
  localparam logic [2:0] CFG_SET_BITS    = 3'd1;
  localparam logic [2:0] CFG_WAYS        = 3'd2;
  localparam logic [2:0] CFG_LRU_MODE    = 3'd3;
  localparam logic [2:0] CFG_PREFETCH    = 3'd4;

  typedef struct packed {
    logic                 operation;
    logic [ADDR_BITS-1:0] address;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  reads_now;
    logic        write_now;
    logic [31:0] total_reads;
    logic [31:0] total_writes;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] tag;
    logic                 vld;
    logic [WAY_W-1:0]     rank;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  function automatic row_t age_row(row_t r, logic [WCNT_W-1:0] ways);
    row_t o;
    logic [WCNT_W-1:0] top;
    o = r;
    top = ways - WCNT_W'(1);
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (WCNT_W'(j) < ways) begin
        if (WCNT_W'(r[j].rank) < top) o[j].rank = r[j].rank + WAY_W'(1);
        else o[j].rank = top[WAY_W-1:0];
      end
    end
    return o;
  endfunction

  function automatic row_t install(row_t r, logic [WAY_W-1:0] way,
                                   logic [ADDR_BITS-1:0] tag, logic [WCNT_W-1:0] ways);
    row_t o;
    o = age_row(r, ways);
    o[way].tag  = tag;
    o[way].rank = '0;
    o[way].vld  = 1'b1;
    return o;
  endfunction

  function automatic logic [WAY_W:0] first_invalid(row_t r, logic [WCNT_W-1:0] ways);
    logic [WAY_W:0] res;
    res = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (WCNT_W'(j) < ways && !r[j].vld) res = {1'b1, WAY_W'(j)};
    end
    return res;
  endfunction

  function automatic logic [WAY_W:0] find_tag(row_t r, logic [WCNT_W-1:0] ways,
                                              logic [ADDR_BITS-1:0] tag);
    logic [WAY_W:0] res;
    res = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (WCNT_W'(j) < ways && r[j].vld && r[j].tag == tag) res = {1'b1, WAY_W'(j)};
    end
    return res;
  endfunction

  function automatic logic [WAY_W-1:0] victim(row_t r, logic [WCNT_W-1:0] ways);
    logic [WAY_W-1:0] res;
    logic [WCNT_W-1:0] top;
    top = ways - WCNT_W'(1);
    res = top[WAY_W-1:0];
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (WCNT_W'(j) < ways && WCNT_W'(r[j].rank) >= top) res = WAY_W'(j);
    end
    return res;
  endfunction

  function automatic row_t promote(row_t r, logic [WAY_W-1:0] way, logic [WCNT_W-1:0] ways);
    row_t o;
    logic [WAY_W-1:0] rk;
    o = r;
    rk = r[way].rank;
    if (rk != '0) begin
      for (int k = 0; k < MAX_WAYS; k++) begin
        if (WCNT_W'(k) < ways && r[k].rank < rk) o[k].rank = r[k].rank + WAY_W'(1);
      end
      o[way].rank = '0;
    end
    return o;
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] v, logic [1:0] by);
    logic [32:0] s;
    s = {1'b0, v} + 33'(by);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- design/set_assoc_cache_with_prefetch_unit.sv -----
// Top level of the set-associative cache unit with FIFO or LRU replacement and prefetch.
// Depends on sacp_pkg and sacp_ram.
//
// Compared with a hit, a prefetching miss adds a look at the next set, two eviction steps
// and, when the next block lies in another set, a second row write-back. While an earlier
// result is still held by a stalled output, the sequencer waits in its final step until that
// result leaves. The next transaction can be accepted in the same cycle in which the result
// appears. The pace is set by the single row memory, which holds one set per row and is read
// through one port and written back through another, and by the sequencer that steps through
// the address split, the lookup and each line install in turn. Rows never written since reset
// read as empty, so no clearing pass is needed.
// Configuration writes are always taken.
module set_assoc_cache_with_prefetch_unit
  import sacp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rsp_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [3:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_BLK, S_TAG, S_LOAD, S_LOOK, S_NLOAD, S_EV1, S_EV2, S_WB1, S_WB2, S_FIN
  } state_e;

  state_e state_q;
  logic [3:0] off_cfg_q, sb_cfg_q, ways_cfg_q;
  logic lru_q, pf_q;
  logic [MAX_SETS-1:0] rowv_q;

  logic                 op_q;
  logic [ADDR_BITS-1:0] addr_q, blk_q, nblk_q, tag_q, ntag_q;
  logic [SET_W-1:0]     set_q, nset_q;
  row_t                 cur_row_q, nrow_q;
  logic hit_q, cur_done_q, have_q, same_q, pfm_q;
  logic [1:0] reads_q;
  logic [31:0] rd_cnt_q, wr_cnt_q, hit_cnt_q, miss_cnt_q;
  logic out_valid_q;
  rsp_t out_q;

  logic [3:0]        off_eff, sb_eff;
  logic [WCNT_W-1:0] ways;
  logic [SET_W-1:0]  smask, set_now, raddr, waddr;
  logic              we;
  row_t              ram_q, mem_row, wdata, wrow, lrow;
  logic [WAY_W:0]    fi, ht, fi2, pr;

  always_comb begin
    off_eff = (off_cfg_q > 4'(OFFSET_CAP)) ? 4'(OFFSET_CAP) : off_cfg_q;
    sb_eff  = (sb_cfg_q > 4'(SET_W)) ? 4'(SET_W) : sb_cfg_q;
    if (ways_cfg_q == 4'd0) ways = WCNT_W'(1);
    else if (ways_cfg_q > 4'(MAX_WAYS)) ways = WCNT_W'(MAX_WAYS);
    else ways = ways_cfg_q[WCNT_W-1:0];
    smask   = SET_W'((SET_W + 1)'(1) << sb_eff) - SET_W'(1);
    set_now = blk_q[SET_W-1:0] & smask;
  end

  assign raddr   = (state_q == S_LOOK) ? nset_q : set_now;
  assign we      = (state_q == S_WB1) || (state_q == S_WB2);
  assign waddr   = (state_q == S_WB2) ? nset_q : set_q;
  assign wdata   = (state_q == S_WB2) ? nrow_q : cur_row_q;
  assign mem_row = rowv_q[(state_q == S_NLOAD) ? nset_q : set_q] ? ram_q : '0;

  sacp_ram #(.WIDTH($bits(row_t)), .DEPTH(MAX_SETS)) u_rows (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ram_q)
  );

  always_comb begin
    ht   = find_tag(cur_row_q, ways, tag_q);
    fi   = first_invalid(cur_row_q, ways);
    wrow = same_q ? cur_row_q : mem_row;
    pr   = find_tag(wrow, ways, ntag_q);
    fi2  = first_invalid(wrow, ways);
    lrow = cur_row_q;
    if (ht[WAY_W]) begin
      if (lru_q) lrow = promote(cur_row_q, ht[WAY_W-1:0], ways);
    end else if (fi[WAY_W]) begin
      lrow = install(cur_row_q, fi[WAY_W-1:0], tag_q, ways);
    end else if (!pf_q) begin
      lrow = install(cur_row_q, victim(cur_row_q, ways), tag_q, ways);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      off_cfg_q   <= 4'd6;
      sb_cfg_q    <= 4'd0;
      ways_cfg_q  <= 4'd1;
      lru_q       <= 1'b0;
      pf_q        <= 1'b0;
      rowv_q      <= '0;
      rd_cnt_q    <= '0;
      wr_cnt_q    <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_OFFSET_BITS: off_cfg_q  <= cfg_data_i;
          CFG_SET_BITS:    sb_cfg_q   <= cfg_data_i;
          CFG_WAYS:        ways_cfg_q <= cfg_data_i;
          CFG_LRU_MODE:    lru_q      <= cfg_data_i[0];
          CFG_PREFETCH:    pf_q       <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && state_q != S_FIN) out_valid_q <= 1'b0;
      if (we) rowv_q[waddr] <= 1'b1;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= in_data_i.operation;
            addr_q  <= in_data_i.address;
            state_q <= S_BLK;
          end
        end
        S_BLK: begin
          blk_q   <= addr_q >> off_eff;
          state_q <= S_TAG;
        end
        S_TAG: begin
          tag_q   <= blk_q >> sb_eff;
          set_q   <= set_now;
          nblk_q  <= (blk_q + ADDR_BITS'(1)) & ({ADDR_BITS{1'b1}} >> off_eff);
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          cur_row_q <= mem_row;
          ntag_q    <= nblk_q >> sb_eff;
          nset_q    <= nblk_q[SET_W-1:0] & smask;
          state_q   <= S_LOOK;
        end
        S_LOOK: begin
          hit_q      <= ht[WAY_W];
          cur_done_q <= fi[WAY_W];
          cur_row_q  <= lrow;
          reads_q    <= ht[WAY_W] ? 2'd0 : 2'd1;
          same_q     <= (nset_q == set_q);
          pfm_q      <= !ht[WAY_W] && pf_q;
          state_q    <= (!ht[WAY_W] && pf_q) ? S_NLOAD : S_WB1;
        end
        S_NLOAD: begin
          have_q <= pr[WAY_W] || fi2[WAY_W];
          if (!pr[WAY_W] && fi2[WAY_W]) begin
            reads_q <= reads_q + 2'd1;
            if (same_q) cur_row_q <= install(wrow, fi2[WAY_W-1:0], ntag_q, ways);
            else nrow_q <= install(wrow, fi2[WAY_W-1:0], ntag_q, ways);
          end else if (!same_q) begin
            nrow_q <= wrow;
          end
          state_q <= S_EV1;
        end
        S_EV1: begin
          if (!cur_done_q)
            cur_row_q <= install(cur_row_q, victim(cur_row_q, ways), tag_q, ways);
          state_q <= S_EV2;
        end
        S_EV2: begin
          if (!have_q) begin
            reads_q <= reads_q + 2'd1;
            if (same_q)
              cur_row_q <= install(cur_row_q, victim(cur_row_q, ways), ntag_q, ways);
            else
              nrow_q <= install(nrow_q, victim(nrow_q, ways), ntag_q, ways);
          end
          state_q <= S_WB1;
        end
        S_WB1: begin
          state_q <= (pfm_q && !same_q) ? S_WB2 : S_FIN;
        end
        S_WB2: begin
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q            <= 1'b1;
            out_q.hit              <= hit_q;
            out_q.reads_now        <= reads_q;
            out_q.write_now        <= op_q;
            out_q.total_reads      <= sat_add(rd_cnt_q, reads_q);
            out_q.total_writes     <= sat_add(wr_cnt_q, {1'b0, op_q});
            out_q.total_hits       <= sat_add(hit_cnt_q, {1'b0, hit_q});
            out_q.total_misses     <= sat_add(miss_cnt_q, {1'b0, !hit_q});
            rd_cnt_q               <= sat_add(rd_cnt_q, reads_q);
            wr_cnt_q               <= sat_add(wr_cnt_q, {1'b0, op_q});
            hit_cnt_q              <= sat_add(hit_cnt_q, {1'b0, hit_q});
            miss_cnt_q             <= sat_add(miss_cnt_q, {1'b0, !hit_q});
            state_q                <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/sacp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sacp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/sacp_checker.sv -----
// Port-level checker for the set-associative cache unit, with its bind statement.
// Depends on sacp_pkg and the top level set_assoc_cache_with_prefetch_unit.
module sacp_checker
  import sacp_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_data_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block accepted a transaction without going busy");

  a_hit_no_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.reads_now == 2'd0)
    else $error("hit reported with memory reads");

  a_miss_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.reads_now == 2'd1 ||
      out_data_o.reads_now == 2'd2)
    else $error("miss reported with a wrong read count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind set_assoc_cache_with_prefetch_unit sacp_checker u_sacp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- sim/set_assoc_cache_with_prefetch_unit_checker.sv -----
// Checker for the set-associative cache unit: tracks configuration writes and access
// transactions, predicts each result from its own copy of the tag store and compares.
// Depends on sacp_pkg.
module set_assoc_cache_with_prefetch_unit_checker
  import sacp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  req_t       in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  rsp_t       out_data_i,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [2:0] cfg_index_i,
  input  logic [3:0] cfg_data_i,
  output int         errors_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES = MAX_SETS * MAX_WAYS;

  logic [ADDR_BITS-1:0] tag_mem [LINES];
  logic                 vld_mem [LINES];
  logic [2:0]           rank_mem [LINES];
  logic [31:0]          reads_cnt, writes_cnt, hits_cnt, misses_cnt;
  logic [3:0]           off_reg, sets_reg, ways_reg;
  logic                 lru_reg, pf_reg;
  rsp_t                 expected_rsps [$];
  int                   errors;

  initial begin
    for (int i = 0; i < LINES; i++) begin
      tag_mem[i] = '0;
      vld_mem[i] = 1'b0;
      rank_mem[i] = '0;
    end
    reads_cnt = '0;
    writes_cnt = '0;
    hits_cnt = '0;
    misses_cnt = '0;
    off_reg = 4'd6;
    sets_reg = 4'd0;
    ways_reg = 4'd1;
    lru_reg = 1'b0;
    pf_reg = 1'b0;
    errors = 0;
  end

  assign errors_o = errors;
  assign pending_o = expected_rsps.size();

  function automatic logic [31:0] bump(logic [31:0] v, int by);
    longint s;
    s = longint'(v) + by;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void age_set(int base, int ways);
    for (int j = 0; j < ways; j++) begin
      if (rank_mem[base+j] < ways - 1) rank_mem[base+j] = rank_mem[base+j] + 3'd1;
      else rank_mem[base+j] = 3'(ways - 1);
    end
  endfunction

  function automatic void fill_line(int base, int way, logic [ADDR_BITS-1:0] tg, int ways);
    tag_mem[base+way] = tg;
    age_set(base, ways);
    rank_mem[base+way] = '0;
    vld_mem[base+way] = 1'b1;
  endfunction

  function automatic int free_way(int base, int ways);
    for (int j = 0; j < ways; j++) if (!vld_mem[base+j]) return j;
    return -1;
  endfunction

  function automatic int lookup(int base, int ways, logic [ADDR_BITS-1:0] tg);
    for (int j = 0; j < ways; j++) if (vld_mem[base+j] && tag_mem[base+j] == tg) return j;
    return -1;
  endfunction

  function automatic int oldest_way(int base, int ways);
    for (int j = 0; j < ways; j++) if (rank_mem[base+j] >= ways - 1) return j;
    return ways - 1;
  endfunction

  function automatic rsp_t predict_access(req_t r);
    rsp_t                 res;
    int                   off, sb, ways, base, nbase, w, hw, w2, nreads;
    logic [ADDR_BITS-1:0] blk, tg, nblk, ntg, smask;
    logic [2:0]           rk;
    bit                   done, have;
    off = (off_reg > OFFSET_CAP) ? OFFSET_CAP : off_reg;
    sb = (sets_reg > SET_W) ? SET_W : sets_reg;
    ways = (ways_reg < 1) ? 1 : ((ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg);
    smask = (ADDR_BITS'(1) << sb) - ADDR_BITS'(1);
    blk = r.address >> off;
    tg = blk >> sb;
    base = int'(blk & smask) * MAX_WAYS;
    nreads = 0;
    hw = lookup(base, ways, tg);
    if (hw >= 0) begin
      hits_cnt = bump(hits_cnt, 1);
      if (lru_reg) begin
        rk = rank_mem[base+hw];
        if (rk != 0) begin
          for (int k = 0; k < ways; k++)
            if (rank_mem[base+k] < rk) rank_mem[base+k] = rank_mem[base+k] + 3'd1;
          rank_mem[base+hw] = '0;
        end
      end
    end else begin
      misses_cnt = bump(misses_cnt, 1);
      nreads = 1;
      done = 1'b0;
      w = free_way(base, ways);
      if (w >= 0) begin
        fill_line(base, w, tg, ways);
        done = 1'b1;
      end
      if (pf_reg) begin
        nblk = (blk + ADDR_BITS'(1)) & ({ADDR_BITS{1'b1}} >> off);
        ntg = nblk >> sb;
        nbase = int'(nblk & smask) * MAX_WAYS;
        have = lookup(nbase, ways, ntg) >= 0;
        if (!have) begin
          w2 = free_way(nbase, ways);
          if (w2 >= 0) begin
            fill_line(nbase, w2, ntg, ways);
            have = 1'b1;
            nreads++;
          end
        end
        if (!done) fill_line(base, oldest_way(base, ways), tg, ways);
        if (!have) begin
          fill_line(nbase, oldest_way(nbase, ways), ntg, ways);
          nreads++;
        end
      end else if (!done) begin
        fill_line(base, oldest_way(base, ways), tg, ways);
      end
    end
    reads_cnt = bump(reads_cnt, nreads);
    writes_cnt = bump(writes_cnt, r.operation ? 1 : 0);
    res.hit = (hw >= 0);
    res.reads_now = 2'(nreads);
    res.write_now = r.operation;
    res.total_reads = reads_cnt;
    res.total_writes = writes_cnt;
    res.total_hits = hits_cnt;
    res.total_misses = misses_cnt;
    return res;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned got_v);
    if (exp_v != got_v) begin
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_OFFSET_BITS: off_reg = cfg_data_i;
          CFG_SET_BITS:    sets_reg = cfg_data_i;
          CFG_WAYS:        ways_reg = cfg_data_i;
          CFG_LRU_MODE:    lru_reg = cfg_data_i[0];
          CFG_PREFETCH:    pf_reg = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_rsps.push_back(predict_access(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result transaction with none expected", $realtime);
        end else begin
          e = expected_rsps.pop_front();
          check_field("hit", e.hit, out_data_i.hit);
          check_field("reads_now", e.reads_now, out_data_i.reads_now);
          check_field("write_now", e.write_now, out_data_i.write_now);
          check_field("total_reads", e.total_reads, out_data_i.total_reads);
          check_field("total_writes", e.total_writes, out_data_i.total_writes);
          check_field("total_hits", e.total_hits, out_data_i.total_hits);
          check_field("total_misses", e.total_misses, out_data_i.total_misses);
        end
      end
    end
  end

endmodule

// ----- sim/set_assoc_cache_with_prefetch_unit_test.sv -----
// Top of the testbench for the set-associative cache unit: clock, reset, configuration
// phases, access stimulus with random idling and the verdict.
// Depends on sacp_pkg, set_assoc_cache_with_prefetch_unit and its checker.
module set_assoc_cache_with_prefetch_unit_test;
  import sacp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk, rst_n;
  logic       in_valid, in_stall, out_valid, out_stall;
  req_t       in_data;
  rsp_t       out_data;
  logic       cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [3:0] cfg_data;
  int         errors, pending;
  int         send_idle_pct, recv_idle_pct;
  bit         hold_off;
  longint     cycles;
  logic [ADDR_BITS-1:0] hot_base;
  longint     hot_span;

  set_assoc_cache_with_prefetch_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  set_assoc_cache_with_prefetch_unit_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 600000) begin
        $display("set_assoc_cache_with_prefetch_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [3:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_mode(int off, int sb, int ways, int lru, int pf);
    int eff_off, eff_sb, eff_ways;
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    write_reg(CFG_OFFSET_BITS, 4'(off));
    write_reg(CFG_SET_BITS, 4'(sb));
    write_reg(CFG_WAYS, 4'(ways));
    write_reg(CFG_LRU_MODE, 4'(lru));
    write_reg(CFG_PREFETCH, 4'(pf));
    cfg_valid <= 1'b0;
    @(posedge clk);
    eff_off = (off > OFFSET_CAP) ? OFFSET_CAP : off;
    eff_sb = (sb > SET_W) ? SET_W : sb;
    eff_ways = (ways < 1) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : ways);
    hot_span = longint'(eff_ways * 3) << (eff_off + eff_sb);
    hot_base = ($urandom_range(0, 3) == 0) ? ({ADDR_BITS{1'b1}} - ADDR_BITS'(hot_span / 2))
                                           : ADDR_BITS'({$urandom, $urandom});
  endtask

  task automatic access(logic op, logic [ADDR_BITS-1:0] addr);
    in_valid <= 1'b1;
    in_data <= '{operation: op, address: addr};
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic random_accesses(int count);
    logic [ADDR_BITS-1:0] a;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) a = hot_base + ADDR_BITS'($urandom_range(0, hot_span));
      else a = ADDR_BITS'({$urandom, $urandom});
      access(1'($urandom_range(0, 1)), a);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_OFFSET_BITS;
    cfg_data = '0;
    hold_off = 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 76;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    access(1'b0, '0);
    access(1'b1, 48'h0000_0000_0010);
    set_mode(12, 8, 8, 1, 1);
    access(1'b0, '0);
    access(1'b1, '0);
    access(1'b0, {ADDR_BITS{1'b1}});
    access(1'b1, 48'hAAAA_5555_AAAA);
    for (int k = 1; k <= 10; k++) access(k[0], ADDR_BITS'(k) << 20);
    access(1'b0, 48'h0000_0010_0000);
    access(1'b0, '0);
    random_accesses(100);

    set_mode(0, 0, 1, 0, 1);
    access(1'b0, 48'h0000_0000_0005);
    access(1'b0, 48'h0000_0000_0006);
    access(1'b1, 48'h0000_0000_0005);
    random_accesses(90);
    set_mode(15, 15, 15, 1, 0);
    random_accesses(100);

    send_idle_pct = 76;
    recv_idle_pct = 38;
    set_mode(4, 2, 4, 0, 1);
    random_accesses(130);
    set_mode(6, 3, 0, 1, 1);
    random_accesses(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_mode(3, 1, 8, 0, 0);
    hold_off = 1'b1;
    random_accesses(180);
    set_mode(5, 4, 3, 1, 1);
    random_accesses(180);
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (30) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("set_assoc_cache_with_prefetch_unit test passed");
    end else begin
      $display("set_assoc_cache_with_prefetch_unit test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/sacp_pkg.sv
design/sacp_ram.sv
design/set_assoc_cache_with_prefetch_unit.sv
design/sacp_checker.sv
sim/set_assoc_cache_with_prefetch_unit_checker.sv
sim/set_assoc_cache_with_prefetch_unit_test.sv
